[rtl/hss_pkg.sv]
`default_nettype none

package hss_pkg;

    localparam int ALPHABET = 256;
    localparam int LEN_W    = 7;
    localparam int OCC_W    = 6;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_PLEN = 1'b0;
    localparam logic REG_FOLD = 1'b1;

    // bad-character table update from a pattern beat
    typedef struct packed {
        logic             clear;
        logic             rec;
        logic [7:0]       sym;
        logic [OCC_W-1:0] idx;
    } t_tbl_wr;

    function automatic logic [7:0] fold(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/horspool_substring_search.sv]
// Horspool search for the first occurrence of a loaded pattern in a byte stream.
// Each beat on start is either a pattern byte or a text byte. A text byte that
// is only buffered needs no compare; a text byte at the current check position
// is compared with the last pattern byte and, on a hit, the earlier pattern
// bytes are compared one at a time during the backward verify, paced by the
// single read port of the pattern and window memories. busy is high during the
// compare and the verify. At most one result beat per search is given on
// o_result_valid for exactly one cycle and cannot be held off; it may overlap
// with the acceptance of the next beat. The search ends at the text byte
// flagged by i_last_byte, after which a new search starts at offset zero.
`default_nettype none

module horspool_substring_search #(
    parameter int MAX_PATTERN = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cmd,
    input  wire logic [5:0]  i_pattern_index,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_last_byte,
    output logic             o_result_valid,
    output logic             o_found,
    output logic [31:0]      o_match_start,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = hss_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_VER  = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [LW-1:0]   r_plen;
    logic            r_fold;
    logic [31:0]     r_count, n_count;
    logic [31:0]     r_nc, n_nc;
    logic            r_done, n_done;
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_cur, n_cur;
    logic [PW-1:0]   r_rp, n_rp;
    logic [PW-1:0]   r_j, n_j;
    logic [7:0]      r_c, n_c;
    logic            r_last, n_last;
    logic [LW-1:0]   r_shift, n_shift;
    logic            r_strobe, n_strobe;
    logic            r_found, n_found;
    logic [31:0]     r_mstart, n_mstart;

    logic [LW-1:0]   w_plen;
    logic [LW-1:0]   w_limit;
    logic            w_take;
    logic            w_cfg_wr;
    logic [32:0]     w_chk;
    logic [32:0]     w_sum;
    logic [31:0]     w_sat;
    logic [LW-1:0]   w_shift_use;
    logic            w_idx_ok;

    logic            pat_we;
    logic [PW-1:0]   pat_waddr;
    logic [PW-1:0]   pat_raddr;
    logic [7:0]      pat_rdata;
    logic            win_we;
    logic [PW-1:0]   win_raddr;
    logic [7:0]      win_rdata;
    hss_pkg::t_tbl_wr tbl_wr;
    logic [7:0]      tbl_sym;
    logic [LW-1:0]   tbl_shift;

    function automatic logic [PW-1:0] f_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(MAX_PATTERN - 1) : (p - 1'b1);
    endfunction

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(MAX_PATTERN - 1)) ? '0 : (p + 1'b1);
    endfunction

    // configuration port
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= LW'(1);
            r_fold <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                hss_pkg::REG_PLEN: r_plen <= pwdata[LW-1:0];
                hss_pkg::REG_FOLD: r_fold <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            hss_pkg::REG_PLEN: prdata = 32'(r_plen);
            hss_pkg::REG_FOLD: prdata = 32'(r_fold);
            default:           prdata = '0;
        endcase
    end

    // effective pattern length
    always_comb begin
        if (r_plen == '0) begin
            w_plen = LW'(1);
        end else if ({2'b00, r_plen} > 9'(MAX_PATTERN)) begin
            w_plen = LW'(MAX_PATTERN);
        end else begin
            w_plen = r_plen;
        end
    end
    assign w_limit = w_plen - 1'b1;

    assign w_take   = start && (r_state == S_IDLE);
    assign w_idx_ok = {3'b000, i_pattern_index} < 9'(MAX_PATTERN);
    assign w_chk    = {1'b0, r_nc} + 33'(w_limit);

    assign w_shift_use = (r_state == S_CMP) ? tbl_shift : r_shift;
    assign w_sum       = {1'b0, r_nc} + 33'(w_shift_use);
    assign w_sat       = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];

    // memory ports
    assign pat_we    = w_take && (i_cmd == hss_pkg::CMD_LOAD) && w_idx_ok;
    assign pat_waddr = PW'(i_pattern_index);
    assign tbl_sym   = hss_pkg::fold(i_byte_value, r_fold);

    always_comb begin
        tbl_wr       = '0;
        tbl_wr.sym   = i_byte_value;
        tbl_wr.idx   = i_pattern_index;
        if (pat_we) begin
            tbl_wr.clear = (i_pattern_index == '0);
            tbl_wr.rec   = (LW'(i_pattern_index) + 1'b1) < w_plen;
        end
    end

    always_comb begin
        pat_raddr = PW'(w_limit);
        win_raddr = f_dec(r_cur);
        unique case (r_state)
            S_IDLE: begin
                pat_raddr = PW'(w_limit);
                win_raddr = f_dec(r_cur);
            end
            S_CMP: begin
                pat_raddr = PW'(w_limit - 1'b1);
                win_raddr = f_dec(r_cur);
            end
            S_VER: begin
                pat_raddr = r_j - 1'b1;
                win_raddr = f_dec(r_rp);
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_nc     = r_nc;
        n_done   = r_done;
        n_wp     = r_wp;
        n_cur    = r_cur;
        n_rp     = r_rp;
        n_j      = r_j;
        n_c      = r_c;
        n_last   = r_last;
        n_shift  = r_shift;
        n_strobe = 1'b0;
        n_found  = r_found;
        n_mstart = r_mstart;
        win_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_take && i_cmd == hss_pkg::CMD_TEXT) begin
                    if (r_done) begin
                        if (i_last_byte) begin
                            n_count = '0;
                            n_nc    = '0;
                            n_done  = 1'b0;
                            n_wp    = '0;
                        end
                    end else if (r_count == 32'hFFFF_FFFF) begin
                        n_done   = 1'b1;
                        n_strobe = 1'b1;
                        n_found  = 1'b0;
                        n_mstart = '0;
                        if (i_last_byte) begin
                            n_count = '0;
                            n_nc    = '0;
                            n_done  = 1'b0;
                            n_wp    = '0;
                        end
                    end else begin
                        win_we  = 1'b1;
                        n_wp    = f_inc(r_wp);
                        n_cur   = r_wp;
                        n_count = r_count + 1'b1;
                        n_c     = tbl_sym;
                        n_last  = i_last_byte;
                        if (w_chk < {1'b0, r_count}) begin
                            n_nc = r_count - 32'(w_limit);
                        end
                        if (w_chk <= {1'b0, r_count}) begin
                            n_state = S_CMP;
                        end else if (i_last_byte) begin
                            n_strobe = 1'b1;
                            n_found  = 1'b0;
                            n_mstart = '0;
                            n_count  = '0;
                            n_nc     = '0;
                            n_wp     = '0;
                        end
                    end
                end
            end

            S_CMP: begin
                n_shift = tbl_shift;
                if (r_c == pat_rdata && w_limit != '0) begin
                    n_j     = PW'(w_limit - 1'b1);
                    n_rp    = f_dec(r_cur);
                    n_state = S_VER;
                end else if (r_c == pat_rdata) begin
                    n_strobe = 1'b1;
                    n_found  = 1'b1;
                    n_mstart = r_nc;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                    if (r_last) begin
                        n_count = '0;
                        n_nc    = '0;
                        n_done  = 1'b0;
                        n_wp    = '0;
                    end
                end else begin
                    n_nc    = w_sat;
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_strobe = 1'b1;
                        n_found  = 1'b0;
                        n_mstart = '0;
                        n_count  = '0;
                        n_nc     = '0;
                        n_wp     = '0;
                    end
                end
            end

            S_VER: begin
                if (pat_rdata != hss_pkg::fold(win_rdata, r_fold)) begin
                    n_nc    = w_sat;
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_strobe = 1'b1;
                        n_found  = 1'b0;
                        n_mstart = '0;
                        n_count  = '0;
                        n_nc     = '0;
                        n_wp     = '0;
                    end
                end else if (r_j == '0) begin
                    n_strobe = 1'b1;
                    n_found  = 1'b1;
                    n_mstart = r_nc;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                    if (r_last) begin
                        n_count = '0;
                        n_nc    = '0;
                        n_done  = 1'b0;
                        n_wp    = '0;
                    end
                end else begin
                    n_j  = r_j - 1'b1;
                    n_rp = f_dec(r_rp);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_nc     <= '0;
            r_done   <= 1'b0;
            r_wp     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_nc     <= n_nc;
            r_done   <= n_done;
            r_wp     <= n_wp;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_rp     <= n_rp;
        r_j      <= n_j;
        r_c      <= n_c;
        r_last   <= n_last;
        r_shift  <= n_shift;
        r_found  <= n_found;
        r_mstart <= n_mstart;
    end

    hss_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATTERN)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (pat_waddr),
        .i_wdata (i_byte_value),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    hss_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATTERN)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (r_wp),
        .i_wdata (i_byte_value),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    hss_shift_table u_shift_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (tbl_wr),
        .i_rd_sym (tbl_sym),
        .i_limit  (w_limit),
        .o_shift  (tbl_shift)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_strobe;
    assign o_found        = r_found;
    assign o_match_start  = r_mstart;

endmodule

`default_nettype wire

[rtl/hss_ram.sv]
`default_nettype none

module hss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/hss_shift_table.sv]
`default_nettype none

module hss_shift_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire hss_pkg::t_tbl_wr          i_wr,
    input  wire logic [7:0]                i_rd_sym,
    input  wire logic [hss_pkg::LEN_W-1:0] i_limit,
    output logic      [hss_pkg::LEN_W-1:0] o_shift
);

    logic [hss_pkg::ALPHABET-1:0] r_valid;
    logic [hss_pkg::ALPHABET-1:0] n_valid;
    logic                         r_hit;
    logic [hss_pkg::OCC_W-1:0]    w_occ;
    logic [hss_pkg::LEN_W-1:0]    w_occ_ext;

    always_comb begin
        n_valid = r_valid;
        if (i_wr.clear) begin
            n_valid = '0;
        end
        if (i_wr.rec) begin
            n_valid[i_wr.sym] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= r_valid[i_rd_sym];
    end

    hss_ram #(
        .WIDTH (hss_pkg::OCC_W),
        .DEPTH (hss_pkg::ALPHABET)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.rec),
        .i_waddr (i_wr.sym),
        .i_wdata (i_wr.idx),
        .i_raddr (i_rd_sym),
        .o_rdata (w_occ)
    );

    assign w_occ_ext = hss_pkg::LEN_W'(w_occ);

    // limit - last occurrence, or the full length when the byte is not in the pattern
    assign o_shift = (r_hit && w_occ_ext < i_limit) ? (i_limit - w_occ_ext)
                                                    : (i_limit + 1'b1);

endmodule

`default_nettype wire

[rtl/hss_checker.sv]
`default_nettype none

module hss_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        i_cmd,
    input wire logic        o_result_valid,
    input wire logic        o_found,
    input wire logic [31:0] o_match_start
);

    // a not-found beat carries offset zero
    a_nofound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_found) |-> (o_match_start == '0))
        else $error("not-found result with nonzero offset");

    // every result beat follows an accepted beat or the end of a verify
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result beat without cause");

    // only a text beat starts a verify
    a_busy_from_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_cmd == hss_pkg::CMD_TEXT))
        else $error("busy without text beat");

    // a pattern beat never yields a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == hss_pkg::CMD_LOAD) |=> !o_result_valid)
        else $error("result after pattern beat");

endmodule

bind horspool_substring_search hss_checker u_hss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .o_result_valid (o_result_valid),
    .o_found        (o_found),
    .o_match_start  (o_match_start)
);

`default_nettype wire

[dv/tb_horspool_substring_search.sv]
module tb_horspool_substring_search;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAT_DEPTH    = 64;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_BEATS = 1150;
    localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;
    localparam logic [7:0] CASE_BOUNDS [6] = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h7B};

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
    } t_search_result;

    typedef enum logic [1:0] {ROW_LOAD, ROW_TEXT, ROW_PLEN, ROW_FOLD} t_row_op;
    typedef enum logic [1:0] {EXP_BY_MODEL, EXP_NOTHING, EXP_TYPED} t_exp_src;

    typedef struct packed {
        t_row_op     op;
        logic [5:0]  idx;
        logic [7:0]  val;
        logic        last;
        t_exp_src    src;
        logic        found;
        logic [31:0] offset;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [28] = '{
        '{ROW_LOAD, 6'h00, 8'h61, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h62, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h61, 1'b0, EXP_TYPED,   1'b1, 32'd1},
        // bytes after a match are dropped up to the last one
        '{ROW_TEXT, 6'h00, 8'hFF, 1'b1, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h00, 1'b1, EXP_TYPED,   1'b0, 32'd0},
        // zero length behaves as one
        '{ROW_PLEN, 6'h00, 8'h00, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h3F, 8'h61, 1'b1, EXP_TYPED,   1'b1, 32'd0},
        '{ROW_FOLD, 6'h00, 8'h01, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h41, 1'b1, EXP_TYPED,   1'b1, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h5B, 1'b1, EXP_TYPED,   1'b0, 32'd0},
        '{ROW_PLEN, 6'h00, 8'h03, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_LOAD, 6'h00, 8'h61, 1'b1, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_LOAD, 6'h01, 8'h62, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_LOAD, 6'h02, 8'h63, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h78, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h61, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h42, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h63, 1'b0, EXP_TYPED,   1'b1, 32'd1},
        '{ROW_TEXT, 6'h00, 8'h71, 1'b1, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h61, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h62, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        // shrink the length after the check position has gone by
        '{ROW_PLEN, 6'h00, 8'h01, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h61, 1'b0, EXP_BY_MODEL, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h80, 1'b1, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_LOAD, 6'h3F, 8'hFF, 1'b1, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h7A, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        // pattern replaced while the search runs
        '{ROW_LOAD, 6'h00, 8'h7A, 1'b0, EXP_NOTHING, 1'b0, 32'd0},
        '{ROW_TEXT, 6'h00, 8'h7A, 1'b1, EXP_BY_MODEL, 1'b0, 32'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cmd;
    logic [5:0]  i_pattern_index;
    logic [7:0]  i_byte_value;
    logic        i_last_byte;
    logic        o_result_valid;
    logic        o_found;
    logic [31:0] o_match_start;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // search state as the block should hold it
    logic [6:0]  len_reg;
    logic        fold_en;
    logic [7:0]  pat_mem [PAT_DEPTH];
    logic [5:0]  last_seen [hss_pkg::ALPHABET];
    logic        seen_ok [hss_pkg::ALPHABET];
    logic [7:0]  win_mem [PAT_DEPTH];
    logic [31:0] text_pos;
    logic [31:0] win_start;
    logic        matched;

    t_search_result result_q [$];
    t_exp_src       beat_src;
    t_search_result beat_typed;

    logic        drv_fold;
    logic [7:0]  pat_shadow [PAT_DEPTH];

    int n_fail;
    int n_loads;
    int n_texts;
    int n_searches;
    int n_hits;
    int n_misses;
    int n_settings;

    horspool_substring_search i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned eff_of(logic [6:0] n);
        if (n == 7'd0) begin
            return 1;
        end
        if (n > 7'd64) begin
            return 64;
        end
        return 32'(n);
    endfunction

    function automatic logic [7:0] lower_case(logic [7:0] b);
        if (fold_en && b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'h20;
        end
        return b;
    endfunction

    task automatic close_search();
        text_pos  = '0;
        win_start = '0;
        matched   = 1'b0;
    endtask

    task automatic predict_beat(input logic cmd, input logic [5:0] idx, input logic [7:0] b,
                                input logic last, output logic emits,
                                output t_search_result res);
        int unsigned    plen;
        int unsigned    lim;
        int unsigned    sh;
        longint unsigned chk;
        longint unsigned nx;
        logic [31:0]    pos;
        logic [7:0]     c;
        logic           ok;
        int             k;
        int             j;
        emits = 1'b0;
        res   = '0;
        plen  = eff_of(len_reg);
        lim   = plen - 1;
        if (cmd == hss_pkg::CMD_LOAD) begin
            if (idx == 6'd0) begin
                for (k = 0; k < hss_pkg::ALPHABET; k++) seen_ok[k] = 1'b0;
            end
            pat_mem[idx] = b;
            if (32'(idx) + 1 < plen) begin
                last_seen[b] = idx;
                seen_ok[b]   = 1'b1;
            end
            return;
        end
        if (matched) begin
            if (last) close_search();
            return;
        end
        pos = text_pos;
        if (pos == COUNT_TOP) begin
            matched = 1'b1;
            if (last) close_search();
            emits = 1'b1;
            return;
        end
        win_mem[pos[5:0]] = b;
        text_pos = pos + 1;
        chk = 64'(win_start) + 64'(lim);
        if (chk < 64'(pos)) begin
            win_start = pos - lim;
            chk       = 64'(pos);
        end
        if (chk == 64'(pos)) begin
            c = lower_case(b);
            if (c == pat_mem[lim]) begin
                ok = 1'b1;
                for (j = int'(lim) - 1; j >= 0; j--) begin
                    if (pat_mem[j] != lower_case(win_mem[6'(win_start + 32'(j))])) begin
                        ok = 1'b0;
                        break;
                    end
                end
                if (ok) begin
                    matched    = 1'b1;
                    emits      = 1'b1;
                    res.found  = 1'b1;
                    res.offset = win_start;
                    if (last) close_search();
                    return;
                end
            end
            if (seen_ok[c] && 32'(last_seen[c]) < lim) begin
                sh = lim - 32'(last_seen[c]);
            end else begin
                sh = plen;
            end
            nx = 64'(win_start) + 64'(sh);
            win_start = (nx > 64'(COUNT_TOP)) ? COUNT_TOP : nx[31:0];
        end
        if (last) begin
            close_search();
            emits = 1'b1;
        end
    endtask

    task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        n_fail++;
        if (n_fail <= 40) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        logic           emits;
        t_search_result res;
        t_search_result want;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == hss_pkg::REG_PLEN) begin
                    len_reg = pwdata[6:0];
                end else begin
                    fold_en = pwdata[0];
                end
            end
            if (start && !busy) begin
                predict_beat(i_cmd, i_pattern_index, i_byte_value, i_last_byte, emits, res);
                if (beat_src == EXP_TYPED) begin
                    result_q.push_back(beat_typed);
                end else if (beat_src == EXP_BY_MODEL && emits) begin
                    result_q.push_back(res);
                end
            end
            if (o_result_valid) begin
                if (result_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 40) begin
                        $display("%0t: result beat with none expected, got found=%0d start=%0d",
                                 $time, o_found, o_match_start);
                    end
                end else begin
                    want = result_q.pop_front();
                    if (want.found) n_hits++; else n_misses++;
                    if (o_found !== want.found) begin
                        note_mismatch("found", 32'(want.found), 32'(o_found));
                    end
                    if (o_match_start !== want.offset) begin
                        note_mismatch("match_start", want.offset, o_match_start);
                    end
                end
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [7:0] pick_pat_byte();
        if ($urandom_range(0, 3) != 0) begin
            return 8'h61 + 8'($urandom_range(0, 3));
        end
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_txt_byte();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            b = 8'h61 + 8'($urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0) b = b - 8'h20;
            return b;
        end
        if (r < 8) begin
            return CASE_BOUNDS[$urandom_range(0, 5)];
        end
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] vary_case(logic [7:0] b);
        if (drv_fold && b >= 8'h61 && b <= 8'h7A && $urandom_range(0, 1) == 1) begin
            return b - 8'h20;
        end
        return b;
    endfunction

    task automatic send_beat(logic cmd, logic [5:0] idx, logic [7:0] b, logic last,
                             t_exp_src src, t_search_result typed);
        @(negedge i_clk);
        start           = 1'b1;
        i_cmd           = cmd;
        i_pattern_index = idx;
        i_byte_value    = b;
        i_last_byte     = last;
        beat_src        = src;
        beat_typed      = typed;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (cmd == hss_pkg::CMD_LOAD) n_loads++; else n_texts++;
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            @(negedge i_clk);
            start           = 1'b0;
            i_cmd           = 1'($urandom);
            i_pattern_index = 6'($urandom);
            i_byte_value    = 8'($urandom);
            i_last_byte     = 1'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // registers only change once every result is in and the block has gone quiet
    task automatic write_reg(logic reg_sel, logic [6:0] field);
        logic [31:0] value;
        value = $urandom;
        if (reg_sel == hss_pkg::REG_PLEN) begin
            value[6:0] = field;
        end else begin
            value[0] = field[0];
            drv_fold = field[0];
        end
        @(negedge i_clk);
        start = 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_beat(logic [5:0] idx, logic [7:0] b, bit no_gap);
        pat_shadow[idx] = b;
        send_beat(hss_pkg::CMD_LOAD, idx, b, 1'($urandom), EXP_BY_MODEL, '0);
        if (!no_gap) pause(gap_len());
    endtask

    task automatic run_search(int unsigned len);
        logic [7:0] txt [$];
        int         tl;
        int         at;
        int         k;
        bit         burst;
        if (len > 20) begin
            tl = $urandom_range(len, len + 40);
        end else if ($urandom_range(0, 3) == 0) begin
            tl = $urandom_range(len, 4 * len + 20);
        end else begin
            tl = $urandom_range(1, 2 * len + 8);
        end
        for (k = 0; k < tl; k++) txt.push_back(pick_txt_byte());
        if ($urandom_range(0, 9) < 6 && tl >= int'(len)) begin
            at = $urandom_range(0, tl - len);
            for (k = 0; k < int'(len); k++) txt[at + k] = vary_case(pat_shadow[k]);
        end
        burst = ($urandom_range(0, 3) == 0);
        for (k = 0; k < tl; k++) begin
            if ($urandom_range(0, 49) == 0) begin
                load_beat(6'($urandom_range(0, len - 1)), pick_pat_byte(), burst);
            end
            send_beat(hss_pkg::CMD_TEXT, 6'($urandom), txt[k], k == tl - 1, EXP_BY_MODEL,
                      '0);
            if (!burst) pause(gap_len());
        end
        n_searches++;
    endtask

    task automatic run_phase(int ph);
        logic [6:0]  setting;
        int unsigned len;
        int          r;
        int          k;
        if (ph == 0) begin
            setting = 7'd64;
        end else if (ph == 1) begin
            setting = 7'd127;
        end else if (ph == 2) begin
            setting = 7'd0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) setting = 7'd64;
            else if (r < 25) setting = 7'($urandom_range(9, 20));
            else setting = 7'($urandom_range(1, 8));
        end
        write_reg(hss_pkg::REG_PLEN, setting);
        write_reg(hss_pkg::REG_FOLD, 7'($urandom_range(0, 1)));
        n_settings++;
        len = eff_of(setting);
        for (k = 0; k < int'(len); k++) load_beat(6'(k), pick_pat_byte(), 1'b0);
        // odd loads: out of order, past the length, or a table clear
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) load_beat(6'($urandom), pick_pat_byte(), 1'b0);
        end
        repeat ((len > 20) ? 1 : $urandom_range(2, 6)) run_search(len);
    endtask

    initial begin
        int ph;
        int base;
        int r;
        int k;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cmd           = hss_pkg::CMD_TEXT;
        i_pattern_index = '0;
        i_byte_value    = '0;
        i_last_byte     = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        beat_src        = EXP_NOTHING;
        beat_typed      = '0;
        drv_fold        = 1'b0;
        len_reg         = 7'd1;
        fold_en         = 1'b0;
        for (k = 0; k < hss_pkg::ALPHABET; k++) begin
            seen_ok[k]   = 1'b0;
            last_seen[k] = '0;
        end
        for (k = 0; k < PAT_DEPTH; k++) begin
            pat_mem[k]    = '0;
            win_mem[k]    = '0;
            pat_shadow[k] = '0;
        end
        close_search();
        n_fail     = 0;
        n_loads    = 0;
        n_texts    = 0;
        n_searches = 0;
        n_hits     = 0;
        n_misses   = 0;
        n_settings = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < 28; r++) begin
            case (DIR_ROWS[r].op)
                ROW_PLEN: begin
                    write_reg(hss_pkg::REG_PLEN, DIR_ROWS[r].val[6:0]);
                end
                ROW_FOLD: begin
                    write_reg(hss_pkg::REG_FOLD, DIR_ROWS[r].val[6:0]);
                end
                default: begin
                    if (DIR_ROWS[r].op == ROW_LOAD) begin
                        pat_shadow[DIR_ROWS[r].idx] = DIR_ROWS[r].val;
                    end
                    send_beat((DIR_ROWS[r].op == ROW_LOAD) ? hss_pkg::CMD_LOAD
                                                           : hss_pkg::CMD_TEXT,
                              DIR_ROWS[r].idx, DIR_ROWS[r].val, DIR_ROWS[r].last,
                              DIR_ROWS[r].src, {DIR_ROWS[r].found, DIR_ROWS[r].offset});
                    pause(gap_len());
                end
            endcase
        end

        base = n_loads + n_texts;
        ph   = 0;
        while (n_loads + n_texts - base < RANDOM_BEATS) begin
            run_phase(ph);
            ph++;
        end

        @(negedge i_clk);
        start = 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d pattern beats and %0d text beats over %0d random searches",
                 n_loads, n_texts, n_searches);
        $display("%0d length and fold settings, %0d matches and %0d no-match results",
                 n_settings, n_hits, n_misses);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
